// ===== hw/rtl/chkv_pkg.sv =====
// Shared types and codes for the chained hash key-value map.
package chkv_pkg;

   typedef enum logic [1:0] {
      CMD_SET        = 2'd0,
      CMD_GET        = 2'd1,
      CMD_REMOVE     = 2'd2,
      CMD_GET_REMOVE = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_FOUND  = 2'd0,
      ST_ABSENT = 2'd1,
      ST_FULL   = 2'd2
   } status_type;

   // controller -> datapath
   typedef struct packed {
      logic load_req;     // capture request, fetch bucket head
      logic read_entry;   // read key/value/link of current entry
      logic step;         // advance walk to the link just read
      logic set_value;    // overwrite value of found entry
      logic alloc;        // take entry from pool and link at bucket head
      logic unlink;       // unlink found entry and push onto free list
      logic load_result;  // capture status and value into the output register
      logic send_done;    // output transfer completed
   } ctrl_type;

   // datapath -> controller
   typedef struct packed {
      logic cur_nil;
      logic key_match;
      logic step_limit;
      logic pool_empty;
      logic rsp_busy;
      cmd_type cmd;
   } stat_type;

endpackage

// ===== hw/rtl/chkv_ctrl.sv =====
// Controller state machine for the chained hash key-value map.
module chkv_ctrl
   import chkv_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  logic     rsp_tready,
   input  stat_type stat,
   output ctrl_type ctrl
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_HEAD,
      S_READ,
      S_CHECK,
      S_ACT,
      S_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      found_ff, found_in;

   always_comb begin
      state_in = state_ff;
      found_in = found_ff;
      ctrl     = '0;
      req_tready = (state_ff == S_IDLE);
      ctrl.send_done = stat.rsp_busy && rsp_tready;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               ctrl.load_req = 1'b1;
               state_in = S_HEAD;
            end
         end
         S_HEAD: begin
            // bucket head is being loaded into the walk pointer
            state_in = S_READ;
         end
         S_READ: begin
            if (stat.cur_nil) begin
               found_in = 1'b0;
               state_in = S_ACT;
            end else begin
               ctrl.read_entry = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (stat.key_match) begin
               found_in = 1'b1;
               state_in = S_ACT;
            end else begin
               ctrl.step = 1'b1;
               if (stat.step_limit) begin
                  found_in = 1'b0;
                  state_in = S_ACT;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_ACT: begin
            if (!stat.rsp_busy || rsp_tready) begin
               ctrl.load_result = 1'b1;
               if (stat.cmd == CMD_SET) begin
                  if (found_ff) ctrl.set_value = 1'b1;
                  else if (!stat.pool_empty) ctrl.alloc = 1'b1;
               end else if (found_ff && stat.cmd != CMD_GET) begin
                  ctrl.unlink = 1'b1;
               end
               state_in = S_OUT;
            end
         end
         S_OUT: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         found_ff <= found_in;
      end
   end

endmodule

// ===== hw/rtl/chkv_dpath.sv =====
// Datapath of the chained hash key-value map: bucket table, entry pool, output register.
module chkv_dpath
   import chkv_pkg::*;
#(
   parameter int BUCKET_BITS = 6,
   parameter int ENTRIES     = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  ctrl_type    ctrl,
   output stat_type    stat,
   input  logic [1:0]  req_cmd,
   input  logic [31:0] req_key,
   input  logic [31:0] req_value_in,
   output logic        rsp_tvalid,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_value_out,
   output logic        clear_busy
);

   localparam int NB = 1 << BUCKET_BITS;
   localparam int IW = $clog2(ENTRIES + 1);
   localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam logic [IW-1:0] NIL = IW'(ENTRIES);

   logic [IW-1:0] bucket_mem [NB];
   logic [31:0]   key_mem    [ENTRIES];
   logic [31:0]   val_mem    [ENTRIES];
   logic [IW-1:0] link_mem   [ENTRIES];

   cmd_type              cmd_ff;
   logic [31:0]          key_ff, val_in_ff;
   logic [BUCKET_BITS-1:0] bkt_ff;
   logic [IW-1:0]        cur_ff, prev_ff, head_ff, free_ff, fresh_ff, steps_ff;
   logic [31:0]          rd_key_ff, rd_val_ff;
   logic [IW-1:0]        rd_link_ff;
   logic                 head_pend_ff;
   logic                 rsp_valid_ff;
   logic [1:0]           rsp_status_ff;
   logic [31:0]          rsp_value_ff;
   logic                 clr_busy_ff;
   logic [BUCKET_BITS-1:0] clr_idx_ff;
   logic [IW-1:0]        new_e;
   logic                 from_free;

   assign from_free = (free_ff != NIL);
   assign new_e = from_free ? free_ff : fresh_ff;
   assign clear_busy = clr_busy_ff;

   always_comb begin
      stat.cur_nil    = (cur_ff >= NIL);
      stat.key_match  = (rd_key_ff == key_ff);
      stat.step_limit = (steps_ff >= NIL - IW'(1));
      stat.pool_empty = !from_free && (fresh_ff >= NIL);
      stat.rsp_busy   = rsp_valid_ff;
      stat.cmd        = cmd_ff;
   end

   // bucket table: clearing pass, head read, writes on alloc/unlink
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         bucket_mem[clr_idx_ff] <= NIL;
      end else if (ctrl.alloc) begin
         bucket_mem[bkt_ff] <= new_e;
      end else if (ctrl.unlink && prev_ff == NIL) begin
         bucket_mem[bkt_ff] <= rd_link_ff;
      end
      if (ctrl.load_req) head_ff <= bucket_mem[req_key[BUCKET_BITS-1:0]];
   end

   always_ff @(posedge clock) begin
      if (ctrl.read_entry) begin
         rd_key_ff  <= key_mem[cur_ff[AW-1:0]];
         rd_val_ff  <= val_mem[cur_ff[AW-1:0]];
         rd_link_ff <= link_mem[cur_ff[AW-1:0]];
      end
      if (ctrl.alloc) begin
         key_mem[new_e[AW-1:0]]  <= key_ff;
         val_mem[new_e[AW-1:0]]  <= val_in_ff;
         link_mem[new_e[AW-1:0]] <= head_ff;
      end else if (ctrl.set_value) begin
         val_mem[cur_ff[AW-1:0]] <= val_in_ff;
      end else if (ctrl.unlink) begin
         link_mem[cur_ff[AW-1:0]] <= free_ff;
         // unlinking a non-head entry writes the predecessor link
         if (prev_ff != NIL) link_mem[prev_ff[AW-1:0]] <= rd_link_ff;
      end
   end

   // free-list pop needs the link of the free head; read it into a register
   logic [IW-1:0] free_next_ff;
   always_ff @(posedge clock) begin
      free_next_ff <= link_mem[free_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_req) begin
         cmd_ff    <= cmd_type'(req_cmd);
         key_ff    <= req_key;
         val_in_ff <= req_value_in;
         bkt_ff    <= req_key[BUCKET_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff   <= 1'b1;
         clr_idx_ff    <= '0;
         free_ff       <= NIL;
         fresh_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         head_pend_ff  <= 1'b0;
         cur_ff        <= NIL;
         prev_ff       <= NIL;
         steps_ff      <= '0;
      end else begin
         if (clr_busy_ff) begin
            clr_idx_ff <= clr_idx_ff + 1'b1;
            if (clr_idx_ff == BUCKET_BITS'(NB - 1)) clr_busy_ff <= 1'b0;
         end
         head_pend_ff <= ctrl.load_req;
         if (head_pend_ff) begin
            cur_ff   <= head_ff;
            prev_ff  <= NIL;
            steps_ff <= '0;
         end else if (ctrl.step) begin
            prev_ff  <= cur_ff;
            cur_ff   <= (rd_link_ff > NIL) ? NIL : rd_link_ff;
            steps_ff <= steps_ff + 1'b1;
         end
         if (ctrl.alloc) begin
            if (from_free) free_ff <= (free_next_ff > NIL) ? NIL : free_next_ff;
            else fresh_ff <= fresh_ff + 1'b1;
         end else if (ctrl.unlink) begin
            free_ff <= cur_ff;
         end
         if (ctrl.load_result) rsp_valid_ff <= 1'b1;
         else if (ctrl.send_done) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_result) begin
         rsp_value_ff <= '0;
         if (ctrl.set_value || ctrl.unlink) begin
            rsp_status_ff <= ST_FOUND;
         end else if (ctrl.alloc) begin
            rsp_status_ff <= ST_ABSENT;
         end else if (cmd_ff == CMD_SET) begin
            rsp_status_ff <= ST_FULL;
         end else if (cmd_ff == CMD_GET && rd_key_ff == key_ff && cur_ff != NIL) begin
            rsp_status_ff <= ST_FOUND;
         end else begin
            rsp_status_ff <= ST_ABSENT;
         end
         if ((cmd_ff == CMD_GET || cmd_ff == CMD_GET_REMOVE) && cur_ff != NIL
             && rd_key_ff == key_ff) begin
            rsp_value_ff <= rd_val_ff;
         end
      end
   end

   assign rsp_tvalid    = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_value_out = rsp_value_ff;

endmodule

// ===== hw/rtl/chained_hash_key_value_map_top.sv =====
// Top level of the chained hash key-value map.
// Each request walks one bucket chain: an accepting step and a head fetch,
// then a read and a key check for each chain entry visited, one more read
// step when the walk runs off the end of the chain, then an update step and
// a step back to idle. The update step waits while an earlier result still
// sits unread in the output register. After reset the bucket table is cleared
// one bucket per cycle, with requests held off.
module chained_hash_key_value_map_top
   import chkv_pkg::*;
#(
   parameter int BUCKET_BITS = 6,
   parameter int ENTRIES     = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // cmd[1:0], key[33:2], value_in[65:34], zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // status[1:0], value_out[33:2], zero fill
);

   ctrl_type    ctrl;
   stat_type    stat;
   logic        ctrl_ready, clear_busy;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_value_out;

   assign req_tready = ctrl_ready && !clear_busy;

   chkv_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid && !clear_busy),
      .req_tready (ctrl_ready),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .ctrl       (ctrl)
   );

   chkv_dpath #(
      .BUCKET_BITS (BUCKET_BITS),
      .ENTRIES     (ENTRIES)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (ctrl),
      .stat          (stat),
      .req_cmd       (req_tdata[1:0]),
      .req_key       (req_tdata[33:2]),
      .req_value_in  (req_tdata[65:34]),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_status    (rsp_status),
      .rsp_value_out (rsp_value_out),
      .clear_busy    (clear_busy)
   );

   assign rsp_tdata = {6'd0, rsp_value_out, rsp_status};

endmodule
